@@ hw/rtl/byte_stream_frame_deframer_crc16_core_defines.svh @@
// Assertion macros for the deframer port-level checker
`ifndef BYTE_STREAM_FRAME_DEFRAMER_CRC16_CORE_DEFINES_SVH
`define BYTE_STREAM_FRAME_DEFRAMER_CRC16_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define BSFD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bsfd check failed");

// next-cycle implication, off during reset
`define BSFD_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bsfd check failed");

// next-cycle implication, always on
`define BSFD_ASSERT_RST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("bsfd check failed");

`endif

@@ hw/rtl/bsfd_pkg.sv @@
// Types, constants and CRC function for the byte stream deframer
`default_nettype none
package bsfd_pkg;

   localparam int HDR_BYTES  = 8;
   localparam int FIFO_DEPTH = 2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_MSB  = 16'h8000;

   localparam logic [6:0] LEN_BAD = 7'd127;

   localparam logic [7:0] START_FIRST_RST  = 8'hAA;
   localparam logic [7:0] START_SECOND_RST = 8'h55;

   // register indexes
   localparam logic CSR_START_FIRST  = 1'b0;
   localparam logic CSR_START_SECOND = 1'b1;

   // frame byte positions
   localparam logic [6:0] POS_HUNT   = 7'd0;
   localparam logic [6:0] POS_SYNC2  = 7'd1;
   localparam logic [6:0] POS_TYPE   = 7'd2;
   localparam logic [6:0] POS_TID_LO = 7'd3;
   localparam logic [6:0] POS_TID_HI = 7'd4;
   localparam logic [6:0] POS_IDENT  = 7'd5;
   localparam logic [6:0] POS_LEN_LO = 7'd6;
   localparam logic [6:0] POS_LEN_HI = 7'd7;

   typedef struct packed {
      logic [7:0]  msg_kind;
      logic [15:0] seq_tag;
      logic [7:0]  identifier;
      logic [6:0]  body_len;
      logic        bank;
   } desc_type;

   typedef struct packed {
      logic       en;
      logic       bank;
      logic [5:0] idx;
      logic [7:0] data;
   } wr_type;

   typedef struct packed {
      logic [7:0]  msg_kind;
      logic [15:0] seq_tag;
      logic [7:0]  identifier;
      logic [6:0]  body_len;
      logic [7:0]  payload_byte;
      logic [5:0]  byte_index;
      logic        byte_valid;
      logic        last_of_frame;
   } rsp_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bsfd_front.sv @@
// Front end: start word hunt, header capture, CRC check, payload write
`default_nettype none
module bsfd_front #(
   parameter int MAX_PAYLOAD = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        data_byte,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [7:0]        csr_wdata,
   output bsfd_pkg::wr_type       wr,
   output logic                   desc_push,
   output bsfd_pkg::desc_type     desc
);

   localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);
   localparam logic [6:0] MAX_L = 7'(MAX_PAYLOAD);
   localparam logic [6:0] HDR_L = 7'(bsfd_pkg::HDR_BYTES);

   logic [7:0]  first_ff, first_in, second_ff, second_in;
   logic [6:0]  pos_ff, pos_in;
   logic        bank_ff, bank_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] tid_ff, tid_in;
   logic [7:0]  ident_ff, ident_in;
   logic [6:0]  len_ff, len_in;
   logic [15:0] crc_next;
   logic [6:0]  pay_end;

   assign crc_next = bsfd_pkg::crc16_byte(crc_ff, data_byte);
   assign pay_end  = HDR_L + len_ff;

   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      if (csr_we) begin
         case (csr_index)
            bsfd_pkg::CSR_START_FIRST:  first_in  = csr_wdata;
            bsfd_pkg::CSR_START_SECOND: second_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      bank_in    = bank_ff;
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      type_in    = type_ff;
      tid_in     = tid_ff;
      ident_in   = ident_ff;
      len_in     = len_ff;
      desc_push  = 1'b0;
      wr.en      = 1'b0;
      wr.bank    = bank_ff;
      wr.idx     = 6'(pos_ff - HDR_L);
      wr.data    = data_byte;
      if (accept) begin
         if (pos_ff == bsfd_pkg::POS_HUNT) begin
            if (data_byte == first_ff) begin
               crc_in = bsfd_pkg::CRC_INIT;
               pos_in = bsfd_pkg::POS_SYNC2;
            end
         end else if (pos_ff == bsfd_pkg::POS_SYNC2) begin
            if (data_byte == second_ff) begin
               pos_in = bsfd_pkg::POS_TYPE;
            end else if (data_byte != first_ff) begin
               pos_in = bsfd_pkg::POS_HUNT;
            end
         end else if (pos_ff < HDR_L) begin
            crc_in = crc_next;
            pos_in = pos_ff + 7'd1;
            case (pos_ff)
               bsfd_pkg::POS_TYPE:   type_in       = data_byte;
               bsfd_pkg::POS_TID_LO: tid_in[7:0]   = data_byte;
               bsfd_pkg::POS_TID_HI: tid_in[15:8]  = data_byte;
               bsfd_pkg::POS_IDENT:  ident_in      = data_byte;
               bsfd_pkg::POS_LEN_LO: len_in = (data_byte > MAX_B) ? bsfd_pkg::LEN_BAD
                                                                  : 7'(data_byte);
               bsfd_pkg::POS_LEN_HI: begin
                  if (data_byte != 8'h00 || len_ff > MAX_L) begin
                     pos_in = bsfd_pkg::POS_HUNT;
                  end
               end
               default: ;
            endcase
         end else if (pos_ff < pay_end) begin
            crc_in = crc_next;
            wr.en  = 1'b1;
            pos_in = pos_ff + 7'd1;
         end else if (pos_ff == pay_end) begin
            crc_low_in = data_byte;
            pos_in     = pos_ff + 7'd1;
         end else begin
            pos_in = bsfd_pkg::POS_HUNT;
            if ({data_byte, crc_low_ff} == crc_ff) begin
               desc_push = 1'b1;
               bank_in   = ~bank_ff;
            end
         end
      end
   end

   assign desc.msg_kind   = type_ff;
   assign desc.seq_tag    = tid_ff;
   assign desc.identifier = ident_ff;
   assign desc.body_len   = len_ff;
   assign desc.bank       = bank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= bsfd_pkg::START_FIRST_RST;
         second_ff <= bsfd_pkg::START_SECOND_RST;
         pos_ff    <= bsfd_pkg::POS_HUNT;
         bank_ff   <= 1'b0;
         crc_ff    <= bsfd_pkg::CRC_INIT;
      end else begin
         first_ff  <= first_in;
         second_ff <= second_in;
         pos_ff    <= pos_in;
         bank_ff   <= bank_in;
         crc_ff    <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_low_ff <= crc_low_in;
      type_ff    <= type_in;
      tid_ff     <= tid_in;
      ident_ff   <= ident_in;
      len_ff     <= len_in;
   end

endmodule
`default_nettype wire

@@ hw/rtl/bsfd_fifo.sv @@
// Two-entry queue of validated frame descriptors
`default_nettype none
module bsfd_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire bsfd_pkg::desc_type push_desc,
   input  wire logic               pop,
   output logic                    full,
   output logic                    head_valid,
   output bsfd_pkg::desc_type      head
);

   localparam logic [1:0] DEPTH_C = 2'(bsfd_pkg::FIFO_DEPTH);

   bsfd_pkg::desc_type ent_ff [bsfd_pkg::FIFO_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == DEPTH_C);
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/bsfd_back.sv @@
// Back end: ping-pong payload memory and per-byte transaction emission
`default_nettype none
module bsfd_back #(
   parameter int MAX_PAYLOAD = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bsfd_pkg::wr_type   wr,
   input  wire logic               desc_valid,
   input  wire bsfd_pkg::desc_type desc,
   output logic                    desc_pop,
   input  wire logic               rsp_pop,
   output logic                    rsp_valid,
   output bsfd_pkg::rsp_type       rsp
);

   localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int DEPTH = 2 ** (AW + 1);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   logic [5:0]        idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic              out_ff, out_in;
   bsfd_pkg::rsp_type st_ff, st_in;
   bsfd_pkg::rsp_type rsp_ff, rsp_in;
   logic              issue, last_item, empty_frame;

   assign empty_frame = (desc.body_len == 7'd0);
   assign last_item   = empty_frame || (7'(idx_ff) + 7'd1 == desc.body_len);
   assign issue       = desc_valid && !pend_ff && (!out_ff || rsp_pop);
   assign desc_pop    = issue && last_item;

   always_comb begin
      idx_in = idx_ff;
      pend_in = issue;
      st_in  = st_ff;
      if (issue) begin
         idx_in              = last_item ? 6'd0 : idx_ff + 6'd1;
         st_in.msg_kind      = desc.msg_kind;
         st_in.seq_tag       = desc.seq_tag;
         st_in.identifier    = desc.identifier;
         st_in.body_len      = desc.body_len;
         st_in.payload_byte  = 8'h00;
         st_in.byte_index    = empty_frame ? 6'd0 : idx_ff;
         st_in.byte_valid    = !empty_frame;
         st_in.last_of_frame = last_item;
      end
   end

   always_comb begin
      out_in = out_ff;
      rsp_in = rsp_ff;
      if (pend_ff) begin
         out_in              = 1'b1;
         rsp_in              = st_ff;
         rsp_in.payload_byte = st_ff.byte_valid ? rdata_ff : 8'h00;
      end else if (rsp_pop) begin
         out_in = 1'b0;
      end
   end

   assign rsp_valid = out_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= 6'd0;
         pend_ff <= 1'b0;
         out_ff  <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         pend_ff <= pend_in;
         out_ff  <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff  <= st_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[{wr.bank, wr.idx[AW-1:0]}] <= wr.data;
      end
      rdata_ff <= mem[{desc.bank, idx_ff[AW-1:0]}];
   end

endmodule
`default_nettype wire

@@ hw/rtl/byte_stream_frame_deframer_crc16_core.sv @@
// Top level of the byte stream frame deframer with CRC-16 check
// Input: one byte per cycle while full is low; full rises while two validated frames still drain.
// Output: first transaction of a good frame passes the descriptor queue, the issue stage and the output register.
// Issue: no new transaction is issued while the previous one still waits on the registered payload read.
// Reset: synchronous, active high; clears parser, queue and output valid,
// start bytes return to 0xAA and 0x55; no memory clearing pass.
`default_nettype none
module byte_stream_frame_deframer_crc16_core #(
   parameter int MAX_PAYLOAD = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_msg_kind,
   output logic [15:0]      rsp_seq_tag,
   output logic [7:0]       rsp_identifier,
   output logic [6:0]       rsp_body_len,
   output logic [7:0]       rsp_payload_byte,
   output logic [5:0]       rsp_byte_index,
   output logic             rsp_byte_valid,
   output logic             rsp_last_of_frame,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   bsfd_pkg::wr_type   wr;
   bsfd_pkg::desc_type push_desc, head;
   bsfd_pkg::rsp_type  rsp;
   logic push, head_valid, head_pop, rsp_valid, fifo_full;

   assign req_full = fifo_full;

   bsfd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_push && !fifo_full),
      .data_byte (req_data_byte),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .wr        (wr),
      .desc_push (push),
      .desc      (push_desc)
   );

   bsfd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (head_pop),
      .full       (fifo_full),
      .head_valid (head_valid),
      .head       (head)
   );

   bsfd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .desc_valid (head_valid),
      .desc       (head),
      .desc_pop   (head_pop),
      .rsp_pop    (rsp_pop),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   assign rsp_empty          = !rsp_valid;
   assign rsp_msg_kind       = rsp.msg_kind;
   assign rsp_seq_tag        = rsp.seq_tag;
   assign rsp_identifier     = rsp.identifier;
   assign rsp_body_len       = rsp.body_len;
   assign rsp_payload_byte   = rsp.payload_byte;
   assign rsp_byte_index     = rsp.byte_index;
   assign rsp_byte_valid     = rsp.byte_valid;
   assign rsp_last_of_frame  = rsp.last_of_frame;

endmodule
`default_nettype wire

@@ hw/rtl/bsfd_checker.sv @@
// Port-level checker for the deframer top level, with its bind
`default_nettype none
`include "byte_stream_frame_deframer_crc16_core_defines.svh"
module bsfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [6:0]  rsp_body_len,
   input wire logic [7:0]  rsp_payload_byte,
   input wire logic [5:0]  rsp_byte_index,
   input wire logic        rsp_byte_valid,
   input wire logic        rsp_last_of_frame
);

   logic [14:0] held_view;
   logic [6:0]  index_wide;
   logic        empty_ok, index_ok;

   assign held_view  = {rsp_payload_byte, rsp_byte_index, rsp_last_of_frame};
   assign index_wide = 7'(rsp_byte_index);
   assign empty_ok   = rsp_last_of_frame && rsp_body_len == 7'd0 && rsp_byte_index == 6'd0
                       && rsp_payload_byte == 8'h00;
   assign index_ok   = rsp_body_len > index_wide
                       && rsp_last_of_frame == (index_wide + 7'd1 == rsp_body_len);

   `BSFD_ASSERT_RST(a_reset_empty, reset, rsp_empty)

   `BSFD_ASSERT_NXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(held_view))

   `BSFD_ASSERT_IMP(a_empty_frame, !rsp_empty && !rsp_byte_valid, empty_ok)

   `BSFD_ASSERT_IMP(a_index_last, !rsp_empty && rsp_byte_valid, index_ok)

endmodule

bind byte_stream_frame_deframer_crc16_core bsfd_checker u_bsfd_checker (.*);
`default_nettype wire

@@ sim/bsfd_frame_checker.sv @@
// CRC helper package and scoreboard checker for the byte stream frame deframer
package frame_crc_calc;

   // CRC-16/CCITT, MSB first, one bit per iteration
   function automatic logic [15:0] crc16_ccitt_next(input logic [15:0] crc,
                                                    input logic [7:0] data);
      logic [15:0] acc;
      logic        fb;
      acc = crc;
      for (int k = 7; k >= 0; k--) begin
         fb  = acc[15] ^ data[k];
         acc = {acc[14:0], 1'b0};
         if (fb) begin
            acc = acc ^ bsfd_pkg::CRC_POLY;
         end
      end
      return acc;
   endfunction
endpackage

module bsfd_frame_checker #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [7:0]  rsp_msg_kind,
   input  logic [15:0] rsp_seq_tag,
   input  logic [7:0]  rsp_identifier,
   input  logic [6:0]  rsp_body_len,
   input  logic [7:0]  rsp_payload_byte,
   input  logic [5:0]  rsp_byte_index,
   input  logic        rsp_byte_valid,
   input  logic        rsp_last_of_frame,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata,
   output int          fail_count,
   output int          pending
);

   logic [7:0]        sync_first;
   logic [7:0]        sync_second;
   logic [6:0]        frame_pos;
   logic [7:0]        hdr_type;
   logic [15:0]       hdr_tid;
   logic [7:0]        hdr_ident;
   logic [6:0]        hdr_len;
   logic [15:0]       crc_acc;
   logic [7:0]        crc_lo;
   logic [7:0]        body_bytes [MAX_PAYLOAD];
   bsfd_pkg::rsp_type deframed_q [$];
   int                errs = 0;

   task automatic deframe_byte(input logic [7:0] b);
      bsfd_pkg::rsp_type r;
      int                n;
      if (frame_pos == bsfd_pkg::POS_HUNT) begin
         if (b == sync_first) begin
            crc_acc   = bsfd_pkg::CRC_INIT;
            frame_pos = bsfd_pkg::POS_SYNC2;
         end
      end else if (frame_pos == bsfd_pkg::POS_SYNC2) begin
         // equal start bytes: advancing wins over re-arming
         if (b == sync_second) begin
            frame_pos = bsfd_pkg::POS_TYPE;
         end else if (b != sync_first) begin
            frame_pos = bsfd_pkg::POS_HUNT;
         end
      end else if (frame_pos < bsfd_pkg::HDR_BYTES) begin
         crc_acc = frame_crc_calc::crc16_ccitt_next(crc_acc, b);
         case (frame_pos)
            bsfd_pkg::POS_TYPE:   hdr_type = b;
            bsfd_pkg::POS_TID_LO: hdr_tid[7:0] = b;
            bsfd_pkg::POS_TID_HI: hdr_tid[15:8] = b;
            bsfd_pkg::POS_IDENT:  hdr_ident = b;
            bsfd_pkg::POS_LEN_LO: hdr_len = (b > MAX_PAYLOAD) ? bsfd_pkg::LEN_BAD : b[6:0];
            default: ;
         endcase
         if (frame_pos == bsfd_pkg::POS_LEN_HI && (b != 8'h00 || hdr_len > MAX_PAYLOAD)) begin
            frame_pos = bsfd_pkg::POS_HUNT;
         end else begin
            frame_pos = frame_pos + 7'd1;
         end
      end else if (frame_pos < bsfd_pkg::HDR_BYTES + hdr_len) begin
         crc_acc = frame_crc_calc::crc16_ccitt_next(crc_acc, b);
         body_bytes[frame_pos - bsfd_pkg::HDR_BYTES] = b;
         frame_pos = frame_pos + 7'd1;
      end else if (frame_pos == bsfd_pkg::HDR_BYTES + hdr_len) begin
         crc_lo    = b;
         frame_pos = frame_pos + 7'd1;
      end else begin
         frame_pos = bsfd_pkg::POS_HUNT;
         if ({b, crc_lo} == crc_acc) begin
            n = (hdr_len == 7'd0) ? 1 : int'(hdr_len);
            for (int i = 0; i < n; i++) begin
               r.msg_kind   = hdr_type;
               r.seq_tag    = hdr_tid;
               r.identifier = hdr_ident;
               r.body_len   = hdr_len;
               if (hdr_len == 7'd0) begin
                  r.payload_byte  = 8'h00;
                  r.byte_index    = 6'd0;
                  r.byte_valid    = 1'b0;
                  r.last_of_frame = 1'b1;
               end else begin
                  r.payload_byte  = body_bytes[i];
                  r.byte_index    = 6'(i);
                  r.byte_valid    = 1'b1;
                  r.last_of_frame = (i == int'(hdr_len) - 1);
               end
               deframed_q.push_back(r);
            end
         end
      end
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         errs++;
         $display("%0t checker: %s expected %0h got %0h", $time, field, want, got);
      end
   endtask

   task automatic compare_rsp(input bsfd_pkg::rsp_type want, input bsfd_pkg::rsp_type got);
      check_field("msg_kind", want.msg_kind, got.msg_kind);
      check_field("seq_tag", want.seq_tag, got.seq_tag);
      check_field("identifier", want.identifier, got.identifier);
      check_field("body_len", want.body_len, got.body_len);
      check_field("payload_byte", want.payload_byte, got.payload_byte);
      check_field("byte_index", want.byte_index, got.byte_index);
      check_field("byte_valid", want.byte_valid, got.byte_valid);
      check_field("last_of_frame", want.last_of_frame, got.last_of_frame);
   endtask

   always @(posedge clock) begin
      bsfd_pkg::rsp_type got;
      if (reset) begin
         sync_first  = bsfd_pkg::START_FIRST_RST;
         sync_second = bsfd_pkg::START_SECOND_RST;
         frame_pos   = bsfd_pkg::POS_HUNT;
         hdr_type    = 8'h00;
         hdr_tid     = 16'h0000;
         hdr_ident   = 8'h00;
         hdr_len     = 7'd0;
         crc_acc     = bsfd_pkg::CRC_INIT;
         crc_lo      = 8'h00;
         deframed_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == bsfd_pkg::CSR_START_FIRST) begin
               sync_first = csr_wdata;
            end else begin
               sync_second = csr_wdata;
            end
         end
         if (rsp_pop && !rsp_empty) begin
            got = {rsp_msg_kind, rsp_seq_tag, rsp_identifier, rsp_body_len,
                   rsp_payload_byte, rsp_byte_index, rsp_byte_valid, rsp_last_of_frame};
            if (deframed_q.size() == 0) begin
               errs++;
               $display("%0t checker: unexpected transaction, expected none %s %0h %0h %0d",
                        $time, "got kind, tag, index", got.msg_kind, got.seq_tag,
                        got.byte_index);
            end else begin
               compare_rsp(deframed_q.pop_front(), got);
            end
         end
         if (req_push && !req_full) begin
            deframe_byte(req_data_byte);
         end
      end
      pending    <= deframed_q.size();
      fail_count <= errs;
   end

endmodule

@@ sim/tb.sv @@
// Testbench top for the byte stream frame deframer: stimulus, watchdog and verdict
module tb;

   localparam int MAX_PAYLOAD  = 32;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_BYTES  = 76;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_push      = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop       = 1'b0;
   logic [7:0]  rsp_msg_kind;
   logic [15:0] rsp_seq_tag;
   logic [7:0]  rsp_identifier;
   logic [6:0]  rsp_body_len;
   logic [7:0]  rsp_payload_byte;
   logic [5:0]  rsp_byte_index;
   logic        rsp_byte_valid;
   logic        rsp_last_of_frame;
   logic        csr_we        = 1'b0;
   logic        csr_index     = bsfd_pkg::CSR_START_FIRST;
   logic [7:0]  csr_wdata     = 8'h00;

   int          fail_count;
   int          pending;
   int          stall_cycles  = 0;
   int          bytes_sent    = 0;
   logic        steady        = 1'b0;
   logic [7:0]  cur_first     = bsfd_pkg::START_FIRST_RST;
   logic [7:0]  cur_second    = bsfd_pkg::START_SECOND_RST;

   byte_stream_frame_deframer_crc16_core #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_msg_kind       (rsp_msg_kind),
      .rsp_seq_tag        (rsp_seq_tag),
      .rsp_identifier     (rsp_identifier),
      .rsp_body_len       (rsp_body_len),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   bsfd_frame_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) chk (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_msg_kind       (rsp_msg_kind),
      .rsp_seq_tag        (rsp_seq_tag),
      .rsp_identifier     (rsp_identifier),
      .rsp_body_len       (rsp_body_len),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      rsp_pop <= steady || ($urandom_range(99) >= 20);
   end

   // no transaction on either side for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // outside steady phases, each cycle idles with one chance in five
   task automatic send_byte(input logic [7:0] b);
      while (!steady && $urandom_range(99) < 20) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bytes_sent++;
   endtask

   // sender holds off until every expected transaction is out
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic program_sync(input logic [7:0] first, input logic [7:0] second);
      csr_we    <= 1'b1;
      csr_index <= bsfd_pkg::CSR_START_FIRST;
      csr_wdata <= first;
      @(posedge clock);
      csr_index <= bsfd_pkg::CSR_START_SECOND;
      csr_wdata <= second;
      @(posedge clock);
      csr_we     <= 1'b0;
      cur_first  = first;
      cur_second = second;
   endtask

   task automatic send_frame(input logic [7:0] ptype, input logic [15:0] tid,
                             input logic [7:0] ident, input logic [15:0] len,
                             input int extra_sync, input logic corrupt, input int cut);
      logic [7:0]  frame_q [$];
      logic [15:0] crc;
      int          idx;
      repeat (extra_sync) frame_q.push_back(cur_first);
      frame_q.push_back(cur_first);
      frame_q.push_back(cur_second);
      frame_q.push_back(ptype);
      frame_q.push_back(tid[7:0]);
      frame_q.push_back(tid[15:8]);
      frame_q.push_back(ident);
      frame_q.push_back(len[7:0]);
      frame_q.push_back(len[15:8]);
      if (len <= MAX_PAYLOAD) begin
         repeat (len) frame_q.push_back(8'($urandom_range(255)));
         crc = bsfd_pkg::CRC_INIT;
         for (idx = extra_sync + 2; idx < frame_q.size(); idx++) begin
            crc = frame_crc_calc::crc16_ccitt_next(crc, frame_q[idx]);
         end
         frame_q.push_back(crc[7:0]);
         frame_q.push_back(crc[15:8]);
         if (corrupt) begin
            idx = $urandom_range(frame_q.size() - 1, extra_sync + 2);
            frame_q[idx] = frame_q[idx] ^ (8'h01 << $urandom_range(7));
         end
      end
      repeat (cut) void'(frame_q.pop_back());
      foreach (frame_q[k]) send_byte(frame_q[k]);
   endtask

   function automatic logic [15:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 16'(MAX_PAYLOAD);
      if (r < 20) return 16'd0;
      return 16'($urandom_range(8, 1));
   endfunction

   function automatic logic [15:0] oversize_length();
      if ($urandom_range(1) == 0) return 16'($urandom_range(255, MAX_PAYLOAD + 1));
      return {8'($urandom_range(255, 1)), 8'($urandom_range(255))};
   endfunction

   task automatic random_frame();
      int pick;
      int extra;
      int n;
      logic [7:0]  ptype;
      logic [15:0] tid;
      logic [7:0]  ident;
      pick  = $urandom_range(99);
      extra = (cur_first != cur_second && $urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
      ptype = 8'($urandom_range(255));
      tid   = 16'($urandom_range(65535));
      ident = 8'($urandom_range(255));
      if (pick < 10) begin
         n = $urandom_range(4, 1);
         repeat (n) send_byte(($urandom_range(3) == 0) ? cur_first : 8'($urandom_range(255)));
      end else if (pick < 20) begin
         send_frame(ptype, tid, ident, pick_length(), extra, 1'b1, 0);
      end else if (pick < 28) begin
         send_frame(ptype, tid, ident, oversize_length(), extra, 1'b0, 0);
      end else if (pick < 33) begin
         send_frame(ptype, tid, ident, pick_length(), extra, 1'b0, $urandom_range(6, 1));
      end else begin
         send_frame(ptype, tid, ident, pick_length(), extra, 1'b0, 0);
      end
   endtask

   task automatic run_phase(input logic [7:0] first, input logic [7:0] second,
                            input logic quiet);
      int phase_end;
      settle();
      program_sync(first, second);
      steady <= quiet;
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) random_frame();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // repeated first start byte, all-ones type and tag, empty payload
      send_frame(8'hFF, 16'hFFFF, 8'h00, 16'd0, 1, 1'b0, 0);
      // low length byte beyond the limit
      send_frame(8'h00, 16'h0000, 8'hFF, 16'(MAX_PAYLOAD + 1), 0, 1'b0, 0);
      // high length byte set
      send_frame(8'h01, 16'h0201, 8'h04, 16'h8001, 0, 1'b0, 0);

      run_phase(8'h00, 8'hFF, 1'b0);
      run_phase(8'hFF, 8'h00, 1'b1);
      run_phase(8'h3C, 8'h3C, 1'b0);
      run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
      run_phase(bsfd_pkg::START_FIRST_RST, bsfd_pkg::START_SECOND_RST, 1'b0);

      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
